// File: hw/rtl/mcfir_pkg.sv
package mcfir_pkg;

  // Item opcodes carried on the mode field.
  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_COEF   = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  // Configuration port layout and register indexes.
  localparam int unsigned CFG_INDEX_BITS = 4;
  localparam int unsigned CFG_DATA_BITS  = 8;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TAPS_IN_USE   = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT = 4'd1;

  // Field widths that the interface fixes.
  localparam int unsigned TAPS_BITS    = 7;
  localparam int unsigned CHCOUNT_BITS = 4;
  localparam int unsigned CHANNEL_BITS = 3;
  localparam int unsigned CIDX_BITS    = 6;

  // Control from the sequencer to the multiply-accumulate datapath.
  typedef struct packed {
    logic start;  // load the rounding constant into the accumulator
    logic issue;  // one tap is being read this cycle
    logic use_x;  // this tap takes the new sample instead of history
  } mac_ctrl_t;

endpackage

// File: hw/rtl/mcfir_coef.sv
module mcfir_coef #(
  parameter int unsigned MAX_TAPS   = 64,
  parameter int unsigned COEFF_BITS = 18
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [$clog2(MAX_TAPS)-1:0]  wr_addr_i,
  input  logic signed [COEFF_BITS-1:0] wr_data_i,
  input  logic                         rd_en_i,
  input  logic [$clog2(MAX_TAPS)-1:0]  rd_addr_i,
  output logic signed [COEFF_BITS-1:0] rd_data_o
);

  logic signed [COEFF_BITS-1:0] mem_q [MAX_TAPS];
  logic [MAX_TAPS-1:0]          valid_q;
  logic signed [COEFF_BITS-1:0] rd_data_q;
  logic                         rd_ok_q;

  // Per-entry valid bits: an entry never written reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_ok_q <= valid_q[rd_addr_i];
      end
    end
  end

  // Coefficient memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_ok_q ? rd_data_q : '0;

endmodule

// File: hw/rtl/mcfir_hist.sv
module mcfir_hist #(
  parameter int unsigned MAX_TAPS     = 64,
  parameter int unsigned MAX_CHANNELS = 8,
  parameter int unsigned SAMPLE_BITS  = 16
) (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                clear_i,
  input  logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] ch_i,
  input  logic                                                rd_en_i,
  input  logic [$clog2(MAX_TAPS)-1:0]                         rd_back_i,
  output logic signed [SAMPLE_BITS-1:0]                       rd_data_o,
  input  logic                                                wr_en_i,
  input  logic signed [SAMPLE_BITS-1:0]                       wr_data_i
);

  localparam int unsigned HIST_LEN = MAX_TAPS - 1;
  localparam int unsigned HIW      = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
  localparam int unsigned HCW      = $clog2(MAX_TAPS);
  localparam int unsigned CHW      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned ADW      = CHW + HIW;
  localparam int unsigned DEPTH    = 1 << ADW;

  logic signed [SAMPLE_BITS-1:0] mem_q [DEPTH];
  logic [HIW-1:0]                wp_q   [MAX_CHANNELS];
  logic [HCW-1:0]                fill_q [MAX_CHANNELS];
  logic [HIW-1:0]                wp_nxt;
  logic [HCW:0]                  wp_ext;
  logic [HCW:0]                  back_ext;
  logic [HCW:0]                  idx_full;
  logic [ADW-1:0]                rd_addr;
  logic signed [SAMPLE_BITS-1:0] rd_data_q;
  logic                          rd_ok_q;

  // Each channel is a ring: the write pointer marks the oldest slot, and an
  // entry k samples back sits k slots behind it, wrapping at the ring length.
  always_comb begin
    wp_ext   = (HCW+1)'(wp_q[ch_i]);
    back_ext = (HCW+1)'(rd_back_i);
    if (back_ext > wp_ext) begin
      idx_full = wp_ext + (HCW+1)'(HIST_LEN) - back_ext;
    end else begin
      idx_full = wp_ext - back_ext;
    end
    rd_addr = {ch_i, HIW'(idx_full)};
    wp_nxt  = (wp_q[ch_i] == HIW'(HIST_LEN - 1)) ? '0 : wp_q[ch_i] + 1'b1;
  end

  // Write pointers and fill counts. A fill count of zero makes the whole
  // channel read as silence, so a clear needs no pass over the memory.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        wp_q[c]   <= '0;
        fill_q[c] <= '0;
      end
      rd_ok_q <= 1'b0;
    end else begin
      if (clear_i) begin
        for (int c = 0; c < MAX_CHANNELS; c++) begin
          fill_q[c] <= '0;
        end
      end else if (wr_en_i) begin
        wp_q[ch_i] <= wp_nxt;
        if (fill_q[ch_i] != HCW'(HIST_LEN)) begin
          fill_q[ch_i] <= fill_q[ch_i] + 1'b1;
        end
      end
      if (rd_en_i) begin
        rd_ok_q <= (rd_back_i <= fill_q[ch_i]);
      end
    end
  end

  // History memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[{ch_i, wp_q[ch_i]}] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign rd_data_o = rd_ok_q ? rd_data_q : '0;

endmodule

// File: hw/rtl/mcfir_mac.sv
module mcfir_mac #(
  parameter int unsigned MAX_TAPS    = 64,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COEFF_BITS  = 18
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mcfir_pkg::mac_ctrl_t          ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] x_i,
  input  logic signed [SAMPLE_BITS-1:0] hist_i,
  input  logic signed [COEFF_BITS-1:0]  coef_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  output logic                          sat_o
);

  localparam int unsigned PW = SAMPLE_BITS + COEFF_BITS;
  localparam int unsigned AW = PW + $clog2(MAX_TAPS);
  localparam int unsigned YW = AW - COEFF_BITS + 1;
  localparam logic signed [AW-1:0] ROUND = AW'(1) << (COEFF_BITS - 2);
  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                          v1_q;
  logic                          v2_q;
  logic                          use_x1_q;
  logic signed [SAMPLE_BITS-1:0] op_a;
  logic signed [PW-1:0]          prod_d;
  logic signed [PW-1:0]          prod_q;
  logic signed [AW-1:0]          acc_q;
  logic signed [YW-1:0]          y;
  logic [YW-SAMPLE_BITS:0]       y_top;
  logic                          ovf;

  // Step valids follow the memory read and the multiply register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      use_x1_q <= 1'b0;
    end else begin
      v1_q     <= ctrl_i.issue;
      v2_q     <= v1_q;
      use_x1_q <= ctrl_i.use_x;
    end
  end

  // Shared multiplier: the newest sample on the first tap, history after.
  always_comb begin
    op_a   = use_x1_q ? x_i : hist_i;
    prod_d = PW'(op_a) * PW'(coef_i);
  end

  // Accumulator starts at the rounding constant so the final shift rounds.
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.start) begin
      acc_q <= ROUND;
    end else if (v2_q) begin
      acc_q <= acc_q + AW'(prod_q);
    end
  end

  // Floor shift to the sample format, then saturate.
  always_comb begin
    y     = acc_q[AW-1:COEFF_BITS-1];
    y_top = y[YW-1:SAMPLE_BITS-1];
    ovf   = !((&y_top) || (~|y_top));
    sat_o = ovf;
    if (ovf) begin
      sample_o = y[YW-1] ? SMIN : SMAX;
    end else begin
      sample_o = y[SAMPLE_BITS-1:0];
    end
  end

endmodule

// File: hw/rtl/multichannel_fir_filter_top.sv
// Multichannel FIR filter over interleaved audio channels.
// Input items arrive on in_valid_i/in_ready_o. Mode sample filters one
// sample of its channel and gives one result on out_valid_o/out_ready_i;
// mode coefficient write and mode clear take effect in the accept cycle and
// give no result. A sample for a channel at or above channel_count is dropped.
// Configuration (tap count, channel count) is written on cfg_valid_i with
// cfg_index_i/cfg_data_i; the user must do so only while the block is idle,
// which the block itself does not enforce; cfg_ready_o is always high.
// A sample is filtered by one multiplier that walks the taps, one per cycle,
// reading the coefficient memory and the channel's history ring; the block
// then drains the read and multiply stages and registers the result. It
// takes no new item until idle again; coefficient writes and clears stay idle.
// At reset the tap count is 64, the channel count 2, all coefficients and
// histories read as zero; no clearing pass is needed.
// The result sits in an output register; if the receiver stalls, the block
// holds a finished sample until the register frees up, then returns to idle.
module multichannel_fir_filter_top #(
  parameter int unsigned MAX_TAPS     = 64,
  parameter int unsigned MAX_CHANNELS = 8,
  parameter int unsigned SAMPLE_BITS  = 16,
  parameter int unsigned COEFF_BITS   = 18
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          cfg_valid_i,
  output logic                                          cfg_ready_o,
  input  logic [mcfir_pkg::CFG_INDEX_BITS-1:0]          cfg_index_i,
  input  logic [mcfir_pkg::CFG_DATA_BITS-1:0]           cfg_data_i,
  input  logic                                          in_valid_i,
  output logic                                          in_ready_o,
  input  logic [1:0]                                    mode_i,
  input  logic [mcfir_pkg::CHANNEL_BITS-1:0]            channel_i,
  input  logic signed [SAMPLE_BITS-1:0]                 sample_in_i,
  input  logic [mcfir_pkg::CIDX_BITS-1:0]               coeff_index_i,
  input  logic signed [COEFF_BITS-1:0]                  coeff_value_i,
  input  logic                                          last_in_block_i,
  output logic                                          out_valid_o,
  input  logic                                          out_ready_i,
  output logic [mcfir_pkg::CHANNEL_BITS-1:0]            channel_out_o,
  output logic signed [SAMPLE_BITS-1:0]                 sample_out_o,
  output logic                                          saturated_o,
  output logic                                          last_out_o
);

  localparam int unsigned CAW = $clog2(MAX_TAPS);
  localparam int unsigned CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [mcfir_pkg::TAPS_BITS-1:0]    taps_q;
  logic [mcfir_pkg::CHCOUNT_BITS-1:0] chcount_q;
  logic [CAW-1:0]                     k_q, k_d;
  logic [CAW-1:0]                     tm1_q, tm1_new;
  logic                               drain_q, drain_d;
  logic [mcfir_pkg::CHANNEL_BITS-1:0] ch_q;
  logic signed [SAMPLE_BITS-1:0]      x_q;
  logic                               last_q;
  logic                               out_valid_q;
  logic [mcfir_pkg::CHANNEL_BITS-1:0] out_ch_q;
  logic signed [SAMPLE_BITS-1:0]      out_sample_q;
  logic                               out_sat_q;
  logic                               out_last_q;

  mcfir_pkg::mode_e     mode;
  mcfir_pkg::mac_ctrl_t mac_ctrl;
  logic                 in_acc;
  logic                 cfg_acc;
  logic                 chan_ok;
  logic                 start;
  logic                 coef_wr;
  logic                 hist_clear;
  logic                 done_fire;
  logic [CAW-1:0]       coef_rd_addr;
  logic signed [COEFF_BITS-1:0]  coef_data;
  logic signed [SAMPLE_BITS-1:0] hist_data;
  logic signed [SAMPLE_BITS-1:0] mac_sample;
  logic                          mac_sat;

  // Handshakes and item decode.
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i & in_ready_o;
  assign mode        = mcfir_pkg::mode_e'(mode_i);
  assign chan_ok     = ({1'b0, channel_i} < chcount_q) && (int'(channel_i) < MAX_CHANNELS);

  always_comb begin
    start      = 1'b0;
    coef_wr    = 1'b0;
    hist_clear = 1'b0;
    unique case (mode)
      mcfir_pkg::MODE_SAMPLE: start      = in_acc && chan_ok;
      mcfir_pkg::MODE_COEF:   coef_wr    = in_acc && (int'(coeff_index_i) < MAX_TAPS);
      mcfir_pkg::MODE_CLEAR:  hist_clear = in_acc;
      default: ;
    endcase
  end

  // Tap count clamped to 1..MAX_TAPS, kept as the index of the last tap.
  always_comb begin
    if (taps_q == '0) begin
      tm1_new = '0;
    end else if (int'(taps_q) > MAX_TAPS) begin
      tm1_new = CAW'(MAX_TAPS - 1);
    end else begin
      tm1_new = CAW'(taps_q - 1'b1);
    end
  end

  // Sequencer: one tap per cycle, then drain the read and multiply stages.
  assign done_fire = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    drain_d = drain_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_RUN;
          k_d     = '0;
        end
      end
      ST_RUN: begin
        if (k_q == tm1_q) begin
          state_d = ST_DRAIN;
          drain_d = 1'b0;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (drain_q) begin
          state_d = ST_DONE;
        end else begin
          drain_d = 1'b1;
        end
      end
      ST_DONE: begin
        if (done_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      drain_q     <= 1'b0;
      taps_q      <= mcfir_pkg::TAPS_BITS'(64);
      chcount_q   <= mcfir_pkg::CHCOUNT_BITS'(2);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      drain_q <= drain_d;
      if (cfg_acc && (cfg_index_i == mcfir_pkg::REG_TAPS_IN_USE)) begin
        taps_q <= cfg_data_i[mcfir_pkg::TAPS_BITS-1:0];
      end
      if (cfg_acc && (cfg_index_i == mcfir_pkg::REG_CHANNEL_COUNT)) begin
        chcount_q <= cfg_data_i[mcfir_pkg::CHCOUNT_BITS-1:0];
      end
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item payload captured at the sample transaction; result register.
  always_ff @(posedge clk_i) begin
    if (start) begin
      tm1_q  <= tm1_new;
      ch_q   <= channel_i;
      x_q    <= sample_in_i;
      last_q <= last_in_block_i;
    end
    if (done_fire) begin
      out_ch_q     <= ch_q;
      out_sample_q <= mac_sample;
      out_sat_q    <= mac_sat;
      out_last_q   <= last_q;
    end
  end

  // Tap walk: the newest sample meets the last coefficient, and coefficient 0 meets the oldest history entry in use.
  assign coef_rd_addr   = tm1_q - k_q;
  assign mac_ctrl.start = start;
  assign mac_ctrl.issue = (state_q == ST_RUN);
  assign mac_ctrl.use_x = (k_q == '0);

  mcfir_coef #(
    .MAX_TAPS   (MAX_TAPS),
    .COEFF_BITS (COEFF_BITS)
  ) u_coef (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (coef_wr),
    .wr_addr_i (CAW'(coeff_index_i)),
    .wr_data_i (coeff_value_i),
    .rd_en_i   (mac_ctrl.issue),
    .rd_addr_i (coef_rd_addr),
    .rd_data_o (coef_data)
  );

  mcfir_hist #(
    .MAX_TAPS     (MAX_TAPS),
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (hist_clear),
    .ch_i      (CHW'(ch_q)),
    .rd_en_i   (mac_ctrl.issue),
    .rd_back_i (k_q),
    .rd_data_o (hist_data),
    .wr_en_i   (done_fire),
    .wr_data_i (x_q)
  );

  mcfir_mac #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEFF_BITS  (COEFF_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .x_i      (x_q),
    .hist_i   (hist_data),
    .coef_i   (coef_data),
    .sample_o (mac_sample),
    .sat_o    (mac_sat)
  );

  assign out_valid_o   = out_valid_q;
  assign channel_out_o = out_ch_q;
  assign sample_out_o  = out_sample_q;
  assign saturated_o   = out_sat_q;
  assign last_out_o    = out_last_q;

endmodule

// File: tb/sv/multichannel_fir_filter_top_test.sv
`timescale 1ns / 1ps

module multichannel_fir_filter_top_test;

  localparam int unsigned TAP_LIMIT     = 64;
  localparam int unsigned CHANNEL_LIMIT = 8;
  localparam int unsigned HISTORY_DEPTH = TAP_LIMIT - 1;
  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned COEFF_W       = 18;
  localparam int unsigned GAP_MAX       = 18;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned DRAIN_CYCLES  = 80;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned PHASE_COUNT   = 12;

  // Opcode that the block must ignore, and a register index with no register behind it.
  localparam logic [1:0] MODE_RESERVED = 2'd3;
  localparam logic [mcfir_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 4'hF;

  typedef struct {
    logic [1:0]                              mode;
    logic [mcfir_pkg::CHANNEL_BITS-1:0]      channel;
    logic signed [SAMPLE_W-1:0]              sample;
    logic [mcfir_pkg::CIDX_BITS-1:0]         cidx;
    logic signed [COEFF_W-1:0]               cval;
    logic                                    last;
  } fir_item_t;

  typedef struct {
    logic [mcfir_pkg::CHANNEL_BITS-1:0]      channel;
    logic signed [SAMPLE_W-1:0]              value;
    logic                                    clipped;
    logic                                    last;
  } fir_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                                     cfg_valid_i = 1'b0;
  logic                                     cfg_ready_o;
  logic [mcfir_pkg::CFG_INDEX_BITS-1:0]     cfg_index_i = '0;
  logic [mcfir_pkg::CFG_DATA_BITS-1:0]      cfg_data_i = '0;
  logic                                     in_valid_i = 1'b0;
  logic                                     in_ready_o;
  logic [1:0]                               mode_i = '0;
  logic [mcfir_pkg::CHANNEL_BITS-1:0]       channel_i = '0;
  logic signed [SAMPLE_W-1:0]               sample_in_i = '0;
  logic [mcfir_pkg::CIDX_BITS-1:0]          coeff_index_i = '0;
  logic signed [COEFF_W-1:0]                coeff_value_i = '0;
  logic                                     last_in_block_i = 1'b0;
  logic                                     out_valid_o;
  logic                                     out_ready_i = 1'b0;
  logic [mcfir_pkg::CHANNEL_BITS-1:0]       channel_out_o;
  logic signed [SAMPLE_W-1:0]               sample_out_o;
  logic                                     saturated_o;
  logic                                     last_out_o;

  // Predictor state: settings, coefficients and per-channel sample history.
  logic [mcfir_pkg::TAPS_BITS-1:0]          taps_setting = 7'd64;
  logic [mcfir_pkg::CHCOUNT_BITS-1:0]       channel_setting = 4'd2;
  logic signed [COEFF_W-1:0]                coeff_table [TAP_LIMIT];
  logic signed [SAMPLE_W-1:0]               channel_history [CHANNEL_LIMIT][HISTORY_DEPTH];

  fir_item_t   pending_items [$];
  fir_result_t expected_samples [$];
  fir_item_t   offered;

  int unsigned items_queued = 0;
  int unsigned items_accepted = 0;
  int unsigned samples_checked = 0;
  int unsigned mismatches = 0;
  int unsigned send_gap_max = GAP_MAX;
  int unsigned recv_gap_max = GAP_MAX;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  int unsigned hold_cycles = 0;
  int unsigned holds_requested = 0;
  int unsigned holds_served = 0;
  int unsigned quiet_cycles = 0;

  multichannel_fir_filter_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .channel_i       (channel_i),
    .sample_in_i     (sample_in_i),
    .coeff_index_i   (coeff_index_i),
    .coeff_value_i   (coeff_value_i),
    .last_in_block_i (last_in_block_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .channel_out_o   (channel_out_o),
    .sample_out_o    (sample_out_o),
    .saturated_o     (saturated_o),
    .last_out_o      (last_out_o)
  );

  initial forever #6 clk_i = ~clk_i;

  // Zero every channel's history, as after reset or on a clear item.
  function automatic void clear_history();
    for (int c = 0; c < CHANNEL_LIMIT; c++) begin
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        channel_history[c][k] = '0;
      end
    end
  endfunction

  // Apply one accepted item to the filter state and queue the sample it produces, if any.
  task automatic predict_filter_output(input fir_item_t it);
    int unsigned taps;
    int unsigned k;
    longint acc;
    longint y;
    fir_result_t r;
    case (it.mode)
      mcfir_pkg::MODE_COEF: begin
        coeff_table[it.cidx] = it.cval;
      end
      mcfir_pkg::MODE_CLEAR: begin
        clear_history();
      end
      mcfir_pkg::MODE_SAMPLE: begin
        if (it.channel < channel_setting) begin
          taps = taps_setting;
          if (taps == 0) taps = 1;
          if (taps > TAP_LIMIT) taps = TAP_LIMIT;
          // The newest sample meets the last active coefficient.
          acc = longint'(it.sample) * longint'(coeff_table[taps-1]);
          for (k = 1; k < taps; k++) begin
            acc += longint'(channel_history[it.channel][k-1]) *
                   longint'(coeff_table[taps-1-k]);
          end
          // Round to nearest with ties upward, then clip to the sample range.
          acc += longint'(1) <<< (COEFF_W - 2);
          y = acc >>> (COEFF_W - 1);
          r.clipped = 1'b0;
          if (y > 32767) begin
            y = 32767;
            r.clipped = 1'b1;
          end
          if (y < -32768) begin
            y = -32768;
            r.clipped = 1'b1;
          end
          for (k = HISTORY_DEPTH - 1; k > 0; k--) begin
            channel_history[it.channel][k] = channel_history[it.channel][k-1];
          end
          channel_history[it.channel][0] = it.sample;
          r.channel = it.channel;
          r.value = y[SAMPLE_W-1:0];
          r.last = it.last;
          expected_samples.push_back(r);
        end
      end
      default: begin
      end
    endcase
  endtask

  function automatic fir_item_t make_item(input logic [1:0] mode,
                                          input logic [mcfir_pkg::CHANNEL_BITS-1:0] ch,
                                          input logic signed [SAMPLE_W-1:0] smp,
                                          input logic [mcfir_pkg::CIDX_BITS-1:0] idx,
                                          input logic signed [COEFF_W-1:0] cv,
                                          input logic last);
    fir_item_t it;
    it.mode = mode;
    it.channel = ch;
    it.sample = smp;
    it.cidx = idx;
    it.cval = cv;
    it.last = last;
    return it;
  endfunction

  // Mostly samples on channels in use; some coefficient loads, clears and ignored items.
  function automatic fir_item_t random_item();
    fir_item_t it;
    logic [31:0] bits;
    int unsigned pick;
    int unsigned live;
    int small_cv;
    bits = $urandom;
    it.sample = bits[SAMPLE_W-1:0];
    bits = $urandom;
    it.cval = bits[COEFF_W-1:0];
    it.cidx = mcfir_pkg::CIDX_BITS'($urandom_range(0, TAP_LIMIT - 1));
    it.channel = mcfir_pkg::CHANNEL_BITS'($urandom_range(0, CHANNEL_LIMIT - 1));
    it.last = 1'($urandom_range(0, 1));
    live = (channel_setting > CHANNEL_LIMIT) ? CHANNEL_LIMIT : channel_setting;
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      it.mode = mcfir_pkg::MODE_SAMPLE;
      if (live != 0 && $urandom_range(0, 99) < 85) begin
        it.channel = mcfir_pkg::CHANNEL_BITS'($urandom_range(0, live - 1));
      end
      if ($urandom_range(0, 9) == 0) begin
        it.sample = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      end
    end else if (pick < 88) begin
      it.mode = mcfir_pkg::MODE_COEF;
      // Mostly modest coefficients so that long filters do not always clip.
      if ($urandom_range(0, 99) < 80) begin
        small_cv = int'($urandom_range(0, 16383)) - 8192;
        it.cval = small_cv[COEFF_W-1:0];
      end
    end else if (pick < 93) begin
      it.mode = mcfir_pkg::MODE_CLEAR;
    end else if (pick < 96) begin
      it.mode = MODE_RESERVED;
    end else begin
      it.mode = mcfir_pkg::MODE_SAMPLE;
    end
    return it;
  endfunction

  task automatic queue_item(input fir_item_t it);
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Write one register on the configuration channel and mirror it in the predictor.
  task automatic write_reg(input logic [mcfir_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [mcfir_pkg::CFG_DATA_BITS-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      mcfir_pkg::REG_TAPS_IN_USE:   taps_setting = data[mcfir_pkg::TAPS_BITS-1:0];
      mcfir_pkg::REG_CHANNEL_COUNT: channel_setting = data[mcfir_pkg::CHCOUNT_BITS-1:0];
      default: begin
      end
    endcase
  endtask

  // Wait until every queued item is taken and every predicted sample has come back.
  task automatic wait_idle(input int unsigned tail);
    while (items_accepted != items_queued || expected_samples.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (tail) @(posedge clk_i);
  endtask

  function automatic void compare_field(input string name,
                                        input logic signed [31:0] expv,
                                        input logic signed [31:0] got);
    if (got !== expv) begin
      mismatches++;
      $error("%s mismatch: expected %0d, got %0d", name, expv, got);
    end
  endfunction

  // Input driver: offers queued items with a random gap between one item and the next.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_filter_output(offered);
        items_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() != 0) begin
          offered = pending_items.pop_front();
          mode_i <= offered.mode;
          channel_i <= offered.channel;
          sample_in_i <= offered.sample;
          coeff_index_i <= offered.cidx;
          coeff_value_i <= offered.cval;
          last_in_block_i <= offered.last;
          in_valid_i <= 1'b1;
          send_wait = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each transaction and throttles out_ready_i.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          mismatches++;
          $error("unexpected result: channel %0d sample %0d", channel_out_o, sample_out_o);
        end else begin
          fir_result_t exp_r;
          exp_r = expected_samples.pop_front();
          compare_field("channel_out", exp_r.channel, channel_out_o);
          compare_field("sample_out", exp_r.value, sample_out_o);
          compare_field("saturated", exp_r.clipped, saturated_o);
          compare_field("last_out", exp_r.last, last_out_o);
          samples_checked++;
        end
        recv_wait = (recv_gap_max == 0) ? 0 : $urandom_range(0, recv_gap_max);
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready_i <= 1'b0;
      end else if (holds_served != holds_requested) begin
        holds_served++;
        hold_cycles = LONG_HOLD;
        out_ready_i <= 1'b0;
      end else if (recv_wait > 0) begin
        if (out_valid_o) recv_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any transaction means the block is hung.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("multichannel_fir_filter_top verification failed");
      $finish;
    end
  end

  // Stimulus sequence: directed items, then random phases over many settings.
  initial begin
    fir_item_t it;
    int unsigned effective;
    int unsigned raw;
    logic [mcfir_pkg::CFG_DATA_BITS-1:0] tap_cfg;
    logic [mcfir_pkg::CFG_DATA_BITS-1:0] chan_cfg;

    clear_history();
    for (int i = 0; i < TAP_LIMIT; i++) coeff_table[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: 64 taps, 2 channels, all coefficients zero.
    queue_item(make_item(mcfir_pkg::MODE_SAMPLE, 3'd0, 16'sd1000, 6'd0, 18'sd0, 1'b0));
    queue_item(make_item(mcfir_pkg::MODE_COEF, 3'd0, 16'sd0, 6'd63, 18'sh1FFFF, 1'b0));
    queue_item(make_item(mcfir_pkg::MODE_COEF, 3'd0, 16'sd0, 6'd62, 18'sh20000, 1'b0));
    queue_item(make_item(mcfir_pkg::MODE_COEF, 3'd0, 16'sd0, 6'd0, 18'sh20000, 1'b0));
    queue_item(make_item(mcfir_pkg::MODE_COEF, 3'd0, 16'sd0, 6'd31, 18'sh10000, 1'b1));
    queue_item(make_item(mcfir_pkg::MODE_SAMPLE, 3'd0, 16'sh7FFF, 6'd0, 18'sd0, 1'b1));
    queue_item(make_item(mcfir_pkg::MODE_SAMPLE, 3'd0, 16'sh8000, 6'd0, 18'sd0, 1'b0));
    queue_item(make_item(mcfir_pkg::MODE_SAMPLE, 3'd0, 16'sh7FFF, 6'd0, 18'sd0, 1'b0));
    queue_item(make_item(mcfir_pkg::MODE_SAMPLE, 3'd1, 16'sh8000, 6'd0, 18'sd0, 1'b0));
    queue_item(make_item(mcfir_pkg::MODE_SAMPLE, 3'd1, 16'sh7FFF, 6'd0, 18'sd0, 1'b1));
    queue_item(make_item(mcfir_pkg::MODE_SAMPLE, 3'd1, 16'sh8000, 6'd0, 18'sd0, 1'b0));
    // Channels beyond the channel count and the unused opcode are dropped.
    queue_item(make_item(mcfir_pkg::MODE_SAMPLE, 3'd2, 16'sh7FFF, 6'd0, 18'sd0, 1'b1));
    queue_item(make_item(mcfir_pkg::MODE_SAMPLE, 3'd7, 16'sh8000, 6'd63, 18'sh1FFFF, 1'b1));
    queue_item(make_item(MODE_RESERVED, 3'd0, 16'sh7FFF, 6'd63, 18'sh20000, 1'b1));
    queue_item(make_item(mcfir_pkg::MODE_SAMPLE, 3'd0, 16'sd0, 6'd0, 18'sd0, 1'b1));
    queue_item(make_item(mcfir_pkg::MODE_CLEAR, 3'd0, 16'sd0, 6'd0, 18'sd0, 1'b0));
    queue_item(make_item(mcfir_pkg::MODE_SAMPLE, 3'd0, -16'sd1, 6'd0, 18'sd0, 1'b0));
    queue_item(make_item(mcfir_pkg::MODE_COEF, 3'd0, 16'sd0, 6'd63, 18'sd1, 1'b0));
    queue_item(make_item(mcfir_pkg::MODE_SAMPLE, 3'd1, 16'sd1, 6'd0, 18'sd0, 1'b0));
    wait_idle(DRAIN_CYCLES);

    // A write to an unused index, then a zero tap count on all eight channels.
    write_reg(REG_UNUSED, 8'hFF);
    write_reg(mcfir_pkg::REG_TAPS_IN_USE, 8'd0);
    write_reg(mcfir_pkg::REG_CHANNEL_COUNT, 8'd8);
    queue_item(make_item(mcfir_pkg::MODE_SAMPLE, 3'd7, 16'sh7FFF, 6'd0, 18'sd0, 1'b1));
    queue_item(make_item(mcfir_pkg::MODE_SAMPLE, 3'd5, 16'sh8000, 6'd0, 18'sd0, 1'b0));
    queue_item(make_item(mcfir_pkg::MODE_SAMPLE, 3'd7, 16'sd3, 6'd0, 18'sd0, 1'b0));
    wait_idle(DRAIN_CYCLES);

    // Upper data bits are dropped; 66 taps clip to the maximum.
    write_reg(mcfir_pkg::REG_TAPS_IN_USE, 8'hC2);
    write_reg(mcfir_pkg::REG_CHANNEL_COUNT, 8'hF3);
    queue_item(make_item(mcfir_pkg::MODE_SAMPLE, 3'd2, 16'sd12345, 6'd0, 18'sd0, 1'b1));
    queue_item(make_item(mcfir_pkg::MODE_SAMPLE, 3'd3, 16'sd12345, 6'd0, 18'sd0, 1'b1));
    wait_idle(DRAIN_CYCLES);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0:  begin tap_cfg = 8'd3;   chan_cfg = 8'd8;  end
        1:  begin tap_cfg = 8'd0;   chan_cfg = 8'd1;  end
        2:  begin tap_cfg = 8'd64;  chan_cfg = 8'd8;  end
        3:  begin tap_cfg = 8'd127; chan_cfg = 8'd3;  end
        4:  begin tap_cfg = 8'd1;   chan_cfg = 8'd15; end
        5:  begin tap_cfg = 8'd8;   chan_cfg = 8'd0;  end
        6:  begin tap_cfg = 8'd2;   chan_cfg = 8'd4;  end
        7:  begin tap_cfg = 8'd16;  chan_cfg = 8'd8;  end
        8:  begin tap_cfg = 8'd40;  chan_cfg = 8'd2;  end
        9:  begin tap_cfg = 8'd5;   chan_cfg = 8'd8;  end
        10: begin tap_cfg = 8'd64;  chan_cfg = 8'd1;  end
        default: begin tap_cfg = 8'd7; chan_cfg = 8'd6; end
      endcase
      write_reg(mcfir_pkg::REG_TAPS_IN_USE, tap_cfg);
      write_reg(mcfir_pkg::REG_CHANNEL_COUNT, chan_cfg);

      // Every fourth phase runs back to back on both sides.
      send_gap_max = (p % 4 == 3) ? 0 : GAP_MAX;
      recv_gap_max = (p % 4 == 3) ? 0 : GAP_MAX;
      // Long output stall while the sender keeps pushing, so the input backs up.
      if (p == 2) begin
        send_gap_max = 0;
        holds_requested++;
      end

      effective = 0;
      raw = 0;
      while ((channel_setting == 0) ? (raw < 20) : (effective < 50)) begin
        it = random_item();
        queue_item(it);
        raw++;
        if (it.mode == mcfir_pkg::MODE_COEF || it.mode == mcfir_pkg::MODE_CLEAR ||
            (it.mode == mcfir_pkg::MODE_SAMPLE && it.channel < channel_setting)) begin
          effective++;
        end
        // Sender pauses halfway until the block has returned every sample.
        if (p == 6 && effective == 25 && raw > 0 && pending_items.size() != 0) begin
          wait_idle(0);
        end
      end
      wait_idle(DRAIN_CYCLES);
    end

    $display("Checked %0d filtered samples from %0d accepted items over %0d tap/channel settings,",
             samples_checked, items_accepted, PHASE_COUNT + 3);
    $display("with saturation, cleared histories, dropped channels and long output back-pressure.");
    if (mismatches == 0) begin
      $display("multichannel_fir_filter_top verification clean");
    end else begin
      $display("multichannel_fir_filter_top verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/mcfir_pkg.sv
hw/rtl/mcfir_coef.sv
hw/rtl/mcfir_hist.sv
hw/rtl/mcfir_mac.sv
hw/rtl/multichannel_fir_filter_top.sv
tb/sv/multichannel_fir_filter_top_test.sv
